// ----- src/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer package
// Shared widths, state and phase codes, register indexes and item types.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int unsigned ALIGN_W = 20;
    localparam int unsigned SWITCH_W = 15;
    localparam int unsigned MODE_W = 4;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned CALIB_W = 16;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned TIMER_W = 20;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned MAG_W = SPEED_W + 1;

    localparam logic [CALIB_W-1:0] CALIB_SAMPLES = 16'd1000;

    localparam logic [ALIGN_W-1:0] ALIGN_TICKS_RST = 20'd5000;
    localparam logic [SWITCH_W-1:0] SWITCH_SPEED_RST = 15'd300;

    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_SPEED = 1'd1;

    localparam logic [STATE_W-1:0] ST_INIT = 3'd0;
    localparam logic [STATE_W-1:0] ST_ADC_CAL = 3'd1;
    localparam logic [STATE_W-1:0] ST_STOP = 3'd2;
    localparam logic [STATE_W-1:0] ST_RUN = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERROR = 3'd4;

    localparam logic [PHASE_W-1:0] PH_DIRECT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ALIGN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DRAG = 2'd2;
    localparam logic [PHASE_W-1:0] PH_OBSERVER = 2'd3;

    localparam logic [MODE_W-1:0] MODE_NONE = 4'd0;
    localparam logic [MODE_W-1:0] MODE_DEBUG_LO = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DEBUG_HI = 4'd4;
    localparam logic [MODE_W-1:0] MODE_RUN_HI = 4'd8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef struct packed {
        logic fault_active;
        logic [MODE_W-1:0] target_mode;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic [CALIB_W-1:0] calib_count;
    } t_in_item;

    typedef struct packed {
        logic [STATE_W-1:0] top_state;
        logic [PHASE_W-1:0] phase;
        logic [TIMER_W-1:0] tick_timer;
    } t_ctl;

    typedef struct packed {
        logic [ALIGN_W-1:0] align_len;
        logic [SWITCH_W-1:0] switch_speed;
    } t_cfg;

endpackage

// ----- src/mss_in_if.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer input channel
// Valid/ready channel carrying one control tick item.
// ----------------------------------------------------------------------------
interface mss_in_if;
    logic valid;
    logic ready;
    logic fault_active;
    logic [mss_pkg::MODE_W-1:0] target_mode;
    logic signed [mss_pkg::SPEED_W-1:0] speed_rpm;
    logic [mss_pkg::CALIB_W-1:0] calib_count;

    modport source (
        output valid, fault_active, target_mode, speed_rpm, calib_count,
        input ready
    );
    modport sink (
        input valid, fault_active, target_mode, speed_rpm, calib_count,
        output ready
    );
endinterface

// ----- src/mss_out_if.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer output channel
// Valid/ready channel carrying the state and phase after one tick.
// ----------------------------------------------------------------------------
interface mss_out_if;
    logic valid;
    logic ready;
    logic [mss_pkg::STATE_W-1:0] machine_state;
    logic [mss_pkg::PHASE_W-1:0] run_phase;

    modport source (
        output valid, machine_state, run_phase,
        input ready
    );
    modport sink (
        input valid, machine_state, run_phase,
        output ready
    );
endinterface

// ----- src/motor_startup_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer core
// Supervisor for a sensorless start: calibration, stop, alignment, forced
// drag and handover to the observer, one control tick per item.
//
//   Channel  Dir  Handshake          Payload
//   i_in     in   valid/ready        fault_active, target_mode, speed_rpm,
//                                    calib_count
//   o_out    out  valid/ready        machine_state, run_phase
//   i_cfg_*  in   write enable only  align_len (0), switch_speed (1)
//
// An item is registered on acceptance and its result is registered as the
// state advances; one item is taken per cycle unless the result stalls.
// The state update sits between the input and result registers.
// A stalled result holds the result register; the input register still
// takes one more item. Reset clears state, timer and valid flags and sets
// the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module motor_startup_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mss_in_if.sink                           i_in,
    mss_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic r_in_valid;
    mss_pkg::t_in_item r_in_item;
    logic r_out_valid;
    logic [mss_pkg::STATE_W-1:0] r_out_state;
    logic [mss_pkg::PHASE_W-1:0] r_out_phase;
    mss_pkg::t_ctl r_ctl;
    mss_pkg::t_ctl n_ctl;
    mss_pkg::t_cfg r_cfg;
    mss_pkg::t_in_item in_item;
    logic out_free;
    logic advance;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign in_item.fault_active = i_in.fault_active;
    assign in_item.target_mode = i_in.target_mode;
    assign in_item.speed_rpm = i_in.speed_rpm;
    assign in_item.calib_count = i_in.calib_count;

    mss_step u_step (
        .i_ctl  (r_ctl),
        .i_cfg  (r_cfg),
        .i_item (r_in_item),
        .o_ctl  (n_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.align_len <= mss_pkg::ALIGN_TICKS_RST;
            r_cfg.switch_speed <= mss_pkg::SWITCH_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mss_pkg::REG_ALIGN_TICKS: begin
                    r_cfg.align_len <= i_cfg_data[mss_pkg::ALIGN_W-1:0];
                end
                mss_pkg::REG_SWITCH_SPEED: begin
                    r_cfg.switch_speed <= i_cfg_data[mss_pkg::SWITCH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl.top_state <= mss_pkg::ST_INIT;
            r_ctl.phase <= mss_pkg::PH_DIRECT;
            r_ctl.tick_timer <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out_state <= n_ctl.top_state;
            r_out_phase <= n_ctl.phase;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.machine_state = r_out_state;
    assign o_out.run_phase = r_out_phase;

endmodule

// ----- src/mss_step.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer step logic
// Next supervisor state, run phase and tick timer for one control tick.
// ----------------------------------------------------------------------------
module mss_step (
    input  mss_pkg::t_ctl     i_ctl,
    input  mss_pkg::t_cfg     i_cfg,
    input  mss_pkg::t_in_item i_item,
    output mss_pkg::t_ctl     o_ctl
);

    logic [mss_pkg::MAG_W-1:0] mag;
    logic [mss_pkg::MAG_W:0] mag_x2;
    logic [mss_pkg::TIMER_W-1:0] timer_inc;
    logic [mss_pkg::STATE_W-1:0] state_eff;
    logic debug_req;
    logic is_other;

    always_comb begin
        if (i_item.speed_rpm[mss_pkg::SPEED_W-1]) begin
            mag = (mss_pkg::MAG_W)'(0) - {i_item.speed_rpm[mss_pkg::SPEED_W-1],
                                           i_item.speed_rpm};
        end else begin
            mag = {1'b0, i_item.speed_rpm};
        end
        mag_x2 = {mag, 1'b0};

        timer_inc = (i_ctl.tick_timer == mss_pkg::TIMER_MAX) ?
                    i_ctl.tick_timer : i_ctl.tick_timer + 1'b1;
        state_eff = i_item.fault_active ? mss_pkg::ST_ERROR : i_ctl.top_state;

        debug_req = (i_item.target_mode >= mss_pkg::MODE_DEBUG_LO) &&
                    (i_item.target_mode <= mss_pkg::MODE_DEBUG_HI);
        is_other = (i_item.target_mode > mss_pkg::MODE_DEBUG_HI) &&
                   (i_item.target_mode <= mss_pkg::MODE_RUN_HI);

        o_ctl.top_state = state_eff;
        o_ctl.phase = i_ctl.phase;
        o_ctl.tick_timer = timer_inc;

        unique case (state_eff)
            mss_pkg::ST_ADC_CAL: begin
                if (i_item.calib_count >= mss_pkg::CALIB_SAMPLES) begin
                    o_ctl.top_state = mss_pkg::ST_STOP;
                end
            end
            mss_pkg::ST_STOP: begin
                if (debug_req || is_other) begin
                    o_ctl.top_state = mss_pkg::ST_RUN;
                    o_ctl.tick_timer = '0;
                    o_ctl.phase = debug_req ? mss_pkg::PH_DIRECT : mss_pkg::PH_ALIGN;
                end
            end
            mss_pkg::ST_RUN: begin
                if (i_item.target_mode == mss_pkg::MODE_NONE) begin
                    o_ctl.top_state = mss_pkg::ST_STOP;
                end else begin
                    unique case (i_ctl.phase)
                        mss_pkg::PH_ALIGN: begin
                            if (timer_inc > i_cfg.align_len) begin
                                o_ctl.phase = mss_pkg::PH_DRAG;
                                o_ctl.tick_timer = '0;
                            end
                        end
                        mss_pkg::PH_DRAG: begin
                            if (mag > {2'b00, i_cfg.switch_speed}) begin
                                o_ctl.phase = mss_pkg::PH_OBSERVER;
                            end
                        end
                        mss_pkg::PH_OBSERVER: begin
                            if (mag_x2 < {3'b000, i_cfg.switch_speed}) begin
                                o_ctl.phase = mss_pkg::PH_DRAG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mss_pkg::ST_ERROR: begin
            end
            default: begin
                o_ctl.top_state = mss_pkg::ST_ADC_CAL;
            end
        endcase
    end

endmodule

// ----- src/mss_checker.sv -----
// ----------------------------------------------------------------------------
// Motor startup sequencer checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module mss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mss_pkg::STATE_W-1:0]   i_machine_state,
    input logic [mss_pkg::PHASE_W-1:0]   i_run_phase
);

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_machine_state <= mss_pkg::ST_ERROR))
        else $error("machine state code out of range");

    a_never_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_machine_state != mss_pkg::ST_INIT))
        else $error("a result reports the init state");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && (i_machine_state == mss_pkg::ST_ERROR)) |=>
        (!i_out_valid || (i_machine_state == mss_pkg::ST_ERROR)))
        else $error("error state left without reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_machine_state) && $stable(i_run_phase)))
        else $error("stalled result changed");

endmodule

bind motor_startup_sequencer_core mss_checker u_mss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_machine_state (o_out.machine_state),
    .i_run_phase     (o_out.run_phase)
);

// ----- verif/tb_motor_startup_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor startup sequencer core testbench
// Sends control ticks through the calibration, stop, alignment, forced drag
// and observer handover paths under several register settings, with random
// stalls on both channels. A scoreboard predicts the state and phase of every
// tick and checks each result in order. A fault ends the run in the error
// state.
// ----------------------------------------------------------------------------
module tb_motor_startup_sequencer_core;
    import mss_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned PHASE_ITEMS = 220;

    typedef struct packed {
        logic [STATE_W-1:0] machine_state;
        logic [PHASE_W-1:0] run_phase;
    } t_status;

    class sequencer_scoreboard;
        logic [STATE_W-1:0] state;
        logic [PHASE_W-1:0] phase;
        logic [TIMER_W-1:0] timer;
        logic [ALIGN_W-1:0] align_len;
        logic [SWITCH_W-1:0] switch_speed;
        t_status expected_status_q[$];
        int unsigned errors;

        function new();
            state = ST_INIT;
            phase = PH_DIRECT;
            timer = '0;
            align_len = ALIGN_TICKS_RST;
            switch_speed = SWITCH_SPEED_RST;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ALIGN_TICKS) begin
                align_len = data[ALIGN_W-1:0];
            end else if (idx == REG_SWITCH_SPEED) begin
                switch_speed = data[SWITCH_W-1:0];
            end
        endfunction

        function int outstanding();
            return expected_status_q.size();
        endfunction

        function void note_tick(t_in_item it);
            logic [MAG_W-1:0] mag;
            t_status res;
            mag = it.speed_rpm[SPEED_W-1] ? {1'b1, {SPEED_W{1'b0}}} - {1'b0, it.speed_rpm}
                                          : {1'b0, it.speed_rpm};
            if (timer != TIMER_MAX) begin
                timer = timer + 1'b1;
            end
            if (it.fault_active) begin
                state = ST_ERROR;
            end
            case (state)
                ST_ADC_CAL: begin
                    if (it.calib_count >= CALIB_SAMPLES) begin
                        state = ST_STOP;
                    end
                end
                ST_STOP: begin
                    if (it.target_mode >= MODE_DEBUG_LO && it.target_mode <= MODE_DEBUG_HI) begin
                        state = ST_RUN;
                        timer = '0;
                        phase = PH_DIRECT;
                    end else if (it.target_mode > MODE_DEBUG_HI
                                 && it.target_mode <= MODE_RUN_HI) begin
                        state = ST_RUN;
                        timer = '0;
                        phase = PH_ALIGN;
                    end
                end
                ST_RUN: begin
                    if (it.target_mode == MODE_NONE) begin
                        state = ST_STOP;
                    end else if (phase == PH_ALIGN) begin
                        if (timer > align_len) begin
                            phase = PH_DRAG;
                            timer = '0;
                        end
                    end else if (phase == PH_DRAG) begin
                        if (mag > MAG_W'(switch_speed)) begin
                            phase = PH_OBSERVER;
                        end
                    end else if (phase == PH_OBSERVER) begin
                        if ({mag, 1'b0} < (MAG_W + 1)'(switch_speed)) begin
                            phase = PH_DRAG;
                        end
                    end
                end
                ST_ERROR: begin
                end
                default: begin
                    state = ST_ADC_CAL;
                end
            endcase
            res.machine_state = state;
            res.run_phase = phase;
            expected_status_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (errors < 40) begin
                $display("%0t ns: mismatch: %s", $time, msg);
            end
            errors++;
        endtask

        task check_status(logic [STATE_W-1:0] st, logic [PHASE_W-1:0] ph);
            t_status exp;
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, state %0d phase %0d",
                                          st, ph));
                return;
            end
            exp = expected_status_q.pop_front();
            if (st !== exp.machine_state) begin
                report_mismatch($sformatf("machine_state %0d, predicted %0d",
                                          st, exp.machine_state));
            end
            if (ph !== exp.run_phase) begin
                report_mismatch($sformatf("run_phase %0d, predicted %0d", ph, exp.run_phase));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic idle_on;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    sequencer_scoreboard sb;

    mss_in_if in_ch();
    mss_out_if out_ch();

    motor_startup_sequencer_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_tick({in_ch.fault_active, in_ch.target_mode, in_ch.speed_rpm,
                              in_ch.calib_count});
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_status(out_ch.machine_state, out_ch.run_phase);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_item make_tick(logic f, int m, int s, int c);
        t_in_item it;
        it.fault_active = f;
        it.target_mode = MODE_W'(m);
        it.speed_rpm = SPEED_W'(s);
        it.calib_count = CALIB_W'(c);
        return it;
    endfunction

    function automatic t_in_item random_tick(logic f);
        t_in_item it;
        int unsigned pick;
        int sw;
        int s;
        sw = int'(sb.switch_speed);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.target_mode = MODE_NONE;
        end else if (pick < 8) begin
            it.target_mode = MODE_W'($urandom_range(MODE_RUN_HI + 1, {MODE_W{1'b1}}));
        end else if (pick < 25) begin
            it.target_mode = MODE_W'($urandom_range(MODE_DEBUG_LO, MODE_DEBUG_HI));
        end else begin
            it.target_mode = MODE_W'($urandom_range(MODE_DEBUG_HI + 1, MODE_RUN_HI));
        end
        case ($urandom_range(0, 4))
            0: s = int'($urandom_range(0, 65535)) - 32768;
            1: s = sw + int'($urandom_range(0, 4)) - 2;
            2: s = sw / 2 + int'($urandom_range(0, 2)) - 1;
            3: s = int'($urandom_range(0, 2 * sw + 2));
            default: begin
                case ($urandom_range(0, 3))
                    0: s = -32768;
                    1: s = 32767;
                    2: s = 0;
                    default: s = -1;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            s = -s;
        end
        it.speed_rpm = SPEED_W'(s);
        it.calib_count = CALIB_W'($urandom);
        it.fault_active = f;
        return it;
    endfunction

    task automatic send_tick(input t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.fault_active <= it.fault_active;
        in_ch.target_mode <= it.target_mode;
        in_ch.speed_rpm <= it.speed_rpm;
        in_ch.calib_count <= it.calib_count;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input logic f);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        send_tick(random_tick(f));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.set_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input int unsigned align, input int unsigned sw,
                               input int unsigned count, input logic idle);
        write_reg(REG_ALIGN_TICKS, CFG_DATA_W'(align));
        write_reg(REG_SWITCH_SPEED, CFG_DATA_W'(sw));
        idle_on = idle;
        repeat (count) send_random(1'b0);
    endtask

    initial begin
        sb = new();
        idle_on = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ALIGN_TICKS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.fault_active = 1'b0;
        in_ch.target_mode = MODE_NONE;
        in_ch.speed_rpm = '0;
        in_ch.calib_count = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 0, CALIB_SAMPLES));
        send_tick(make_tick(1'b0, MODE_NONE, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_NONE, 0, CALIB_SAMPLES - 1));
        send_tick(make_tick(1'b0, MODE_NONE, 0, CALIB_SAMPLES));
        send_tick(make_tick(1'b0, MODE_NONE, 0, 16'hFFFF));
        send_tick(make_tick(1'b0, MODE_RUN_HI + 1, 0, 16'd0));
        send_tick(make_tick(1'b0, {MODE_W{1'b1}}, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_LO, 0, 16'd0));
        send_tick(make_tick(1'b0, {MODE_W{1'b1}}, 32767, 16'd0));
        send_tick(make_tick(1'b0, MODE_NONE, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI, -1, 16'd0));
        send_tick(make_tick(1'b0, MODE_NONE, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_RUN_HI, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 2, -32768, 16'd0));
        send_tick(make_tick(1'b0, MODE_NONE, 0, 16'd0));

        // A short alignment so that forced drag and the observer are reached.
        write_reg(REG_ALIGN_TICKS, CFG_DATA_W'(2));
        send_tick(make_tick(1'b0, MODE_RUN_HI - 1, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 0, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 300, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, -301, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 150, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, -149, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, -32768, 16'd0));
        send_tick(make_tick(1'b0, MODE_DEBUG_HI + 1, 0, 16'd0));

        run_setting(0, 0, PHASE_ITEMS, 1'b1);
        run_setting(32'hFFFFF, 32767, PHASE_ITEMS, 1'b1);
        run_setting(3, 300, PHASE_ITEMS, 1'b0);
        run_setting($urandom_range(0, 30), $urandom_range(0, 32767), PHASE_ITEMS, 1'b1);
        run_setting($urandom_range(0, 30), $urandom_range(0, 600), PHASE_ITEMS, 1'b1);
        run_setting(1, 1, PHASE_ITEMS, 1'b1);
        run_setting($urandom_range(0, 20), $urandom_range(0, 1000), 190, 1'b0);

        // A fault is final: every tick after it must report the error state.
        repeat (5) send_random(1'b0);
        send_random(1'b1);
        repeat (9) send_random(1'($urandom_range(0, 1)));

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
